// ===== src/cfd_pkg.sv =====
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared types and constants for the command frame decoder.
// ----------------------------------------------------------------------------
package cfd_pkg;

  localparam int unsigned FRAME_LENGTH  = 46;
  localparam int unsigned HEADER_LENGTH = 2;
  localparam int unsigned POS_W         = 6;

  localparam logic [7:0] HEADER_FIRST_RST  = 8'hEB;
  localparam logic [7:0] HEADER_SECOND_RST = 8'h90;

  // Configuration register indexes.
  localparam logic CFG_HEADER_FIRST  = 1'b0;
  localparam logic CFG_HEADER_SECOND = 1'b1;

  // Command codes carried in frame byte two.
  localparam logic [7:0] CMD_REFRESH_LO   = 8'h90;
  localparam logic [7:0] CMD_REFRESH_HI   = 8'h91;
  localparam logic [7:0] CMD_GAIN_PRE     = 8'h92;
  localparam logic [7:0] CMD_GAIN_SET     = 8'h93;
  localparam logic [7:0] CMD_EXPO_PRE     = 8'h94;
  localparam logic [7:0] CMD_EXPO_SET     = 8'h95;
  localparam logic [7:0] CMD_FWD_A        = 8'h96;
  localparam logic [7:0] CMD_FWD_B        = 8'h97;
  localparam logic [7:0] CMD_START        = 8'h98;
  localparam logic [7:0] CMD_STOP         = 8'h99;
  localparam logic [7:0] CMD_XFER         = 8'h9A;
  localparam logic [7:0] CMD_STOP_XFER    = 8'h9B;
  localparam logic [7:0] CMD_POWER_OFF    = 8'h9C;
  localparam logic [7:0] CMD_FORMAT       = 8'h9D;
  localparam logic [7:0] CMD_FWD_C        = 8'h9E;

  typedef enum logic [3:0] {
    KIND_BAD_SUM   = 4'd0,
    KIND_FORWARD   = 4'd1,
    KIND_GAIN_PRE  = 4'd2,
    KIND_EXPO_PRE  = 4'd3,
    KIND_START     = 4'd4,
    KIND_STOP      = 4'd5,
    KIND_XFER      = 4'd6,
    KIND_STOP_XFER = 4'd7,
    KIND_POWER_OFF = 4'd8,
    KIND_FORMAT    = 4'd9,
    KIND_REJECTED  = 4'd10,
    KIND_UNKNOWN   = 4'd11,
    KIND_REFRESH   = 4'd12
  } kind_e;

  // A completed frame waiting for decode.
  typedef struct packed {
    logic        sum_ok;
    logic [7:0]  cmd;
    logic [31:0] args;
  } frame_t;

  typedef struct packed {
    logic [31:0] value;
    logic [7:0]  sub_c;
    logic [7:0]  sub_b;
    logic [7:0]  sub_a;
    logic [7:0]  addr;
    logic [7:0]  code;
    kind_e       kind;
  } result_t;

endpackage

// ===== src/command_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// command_frame_decoder
// Command frame decoder for a received byte stream.
// ----------------------------------------------------------------------------
// One byte is taken per beat, one beat per cycle, as long as the completed
// frame register is free or draining; a completed 46-byte frame with a valid
// two-byte header gives one result beat via the frame and result registers.
// The rate is set by the single pass through the frame tracker, whose
// running sum and position counter update on every byte. The result kind
// travels on tuser; bad-sum, confirmation, rejected and unknown results carry
// zero camera fields. Header bytes are to be written by the user through the
// configuration port only while the block is idle; the block does not check.
module command_frame_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // command_code, camera_addr, camera_sub_a, camera_sub_b, camera_sub_c,
  // camera_value
  output logic [71:0] m_axis_tdata_o,
  output logic [3:0]  m_axis_tuser_o,   // result_kind
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  logic [7:0]       header_first_q, header_second_q;
  logic             beat, frame_valid, load_ready, advance;
  cfd_pkg::frame_t  frame;
  cfd_pkg::result_t decoded, result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_first_q  <= cfd_pkg::HEADER_FIRST_RST;
      header_second_q <= cfd_pkg::HEADER_SECOND_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        cfd_pkg::CFG_HEADER_FIRST:  header_first_q  <= cfg_data_i;
        cfd_pkg::CFG_HEADER_SECOND: header_second_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign advance         = frame_valid && load_ready;
  assign s_axis_tready_o = !frame_valid || load_ready;
  assign beat            = s_axis_tvalid_i && s_axis_tready_o;

  cfd_frame u_frame (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .beat_i          (beat),
    .byte_i          (s_axis_tdata_i),
    .header_first_i  (header_first_q),
    .header_second_i (header_second_q),
    .advance_i       (advance),
    .frame_valid_o   (frame_valid),
    .frame_o         (frame)
  );

  cfd_decode u_decode (
    .frame_i  (frame),
    .result_o (decoded)
  );

  cfd_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (frame_valid),
    .result_i     (decoded),
    .load_ready_o (load_ready),
    .valid_o      (m_axis_tvalid_o),
    .ready_i      (m_axis_tready_i),
    .result_o     (result)
  );

  assign m_axis_tuser_o = result.kind;
  assign m_axis_tdata_o = {result.value, result.sub_c, result.sub_b, result.sub_a,
                           result.addr, result.code};

endmodule

// ===== src/cfd_frame.sv =====
// ----------------------------------------------------------------------------
// cfd_frame
// Header hunt, byte counting, running sum and argument capture.
// ----------------------------------------------------------------------------
module cfd_frame (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            beat_i,
  input  logic [7:0]      byte_i,
  input  logic [7:0]      header_first_i,
  input  logic [7:0]      header_second_i,
  input  logic            advance_i,
  output logic            frame_valid_o,
  output cfd_pkg::frame_t frame_o
);

  logic [cfd_pkg::POS_W-1:0] pos_q, pos_d;
  logic [7:0]                sum_q, sum_d;
  logic [7:0]                cmd_q, cmd_d;
  logic [31:0]               args_q, args_d;
  logic                      frame_valid_q, frame_valid_d;
  cfd_pkg::frame_t           frame_q, frame_d;
  logic                      in_header, hdr_miss, last_byte;

  assign in_header = pos_q < cfd_pkg::POS_W'(cfd_pkg::HEADER_LENGTH);
  assign hdr_miss  = in_header &&
                     (byte_i != ((pos_q == '0) ? header_first_i : header_second_i));
  assign last_byte = pos_q == cfd_pkg::POS_W'(cfd_pkg::FRAME_LENGTH - 1);

  always_comb begin
    pos_d         = pos_q;
    sum_d         = sum_q;
    cmd_d         = cmd_q;
    args_d        = args_q;
    frame_valid_d = frame_valid_q && !advance_i;
    frame_d       = frame_q;
    if (beat_i) begin
      if (hdr_miss) begin
        pos_d = '0;
        sum_d = '0;
      end else if (last_byte) begin
        frame_valid_d  = 1'b1;
        frame_d.sum_ok = byte_i == sum_q;
        frame_d.cmd    = cmd_q;
        frame_d.args   = args_q;
        pos_d          = '0;
        sum_d          = '0;
      end else begin
        case (pos_q)
          cfd_pkg::POS_W'(2): cmd_d = byte_i;
          cfd_pkg::POS_W'(3): args_d[7:0]   = byte_i;
          cfd_pkg::POS_W'(4): args_d[15:8]  = byte_i;
          cfd_pkg::POS_W'(5): args_d[23:16] = byte_i;
          cfd_pkg::POS_W'(6): args_d[31:24] = byte_i;
          default: ;
        endcase
        sum_d = sum_q + byte_i;
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q         <= '0;
      sum_q         <= '0;
      cmd_q         <= '0;
      args_q        <= '0;
      frame_valid_q <= 1'b0;
    end else begin
      pos_q         <= pos_d;
      sum_q         <= sum_d;
      cmd_q         <= cmd_d;
      args_q        <= args_d;
      frame_valid_q <= frame_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
  end

  assign frame_valid_o = frame_valid_q;
  assign frame_o       = frame_q;

endmodule

// ===== src/cfd_decode.sv =====
// ----------------------------------------------------------------------------
// cfd_decode
// Maps a completed frame to a result kind and camera register bytes.
// ----------------------------------------------------------------------------
module cfd_decode (
  input  cfd_pkg::frame_t  frame_i,
  output cfd_pkg::result_t result_o
);

  logic confirmed;

  // Confirmation commands repeat the command byte in all four argument bytes.
  assign confirmed = frame_i.args == {4{frame_i.cmd}};

  always_comb begin
    result_o       = '0;
    result_o.code  = frame_i.cmd;
    result_o.kind  = cfd_pkg::KIND_BAD_SUM;
    if (frame_i.sum_ok) begin
      case (frame_i.cmd)
        cfd_pkg::CMD_REFRESH_LO: begin
          result_o.kind  = cfd_pkg::KIND_REFRESH;
          result_o.addr  = 8'h04;
          result_o.sub_a = 8'h02;
          result_o.sub_b = 8'h03;
          result_o.value = frame_i.args;
        end
        cfd_pkg::CMD_REFRESH_HI: begin
          result_o.kind  = cfd_pkg::KIND_REFRESH;
          result_o.addr  = 8'h24;
          result_o.sub_a = 8'h02;
          result_o.sub_b = 8'h03;
          result_o.value = frame_i.args;
        end
        cfd_pkg::CMD_GAIN_PRE: begin
          result_o.kind  = cfd_pkg::KIND_GAIN_PRE;
          result_o.addr  = 8'h04;
          result_o.sub_b = 8'h02;
          result_o.value = frame_i.args;
        end
        cfd_pkg::CMD_GAIN_SET: begin
          result_o.kind  = cfd_pkg::KIND_FORWARD;
          result_o.addr  = 8'h04;
          result_o.sub_b = 8'h02;
          result_o.value = 32'd2;
        end
        cfd_pkg::CMD_EXPO_PRE: begin
          result_o.kind  = cfd_pkg::KIND_EXPO_PRE;
          result_o.addr  = 8'h24;
          result_o.sub_a = 8'h04;
          result_o.sub_b = 8'h04;
          result_o.value = frame_i.args;
        end
        cfd_pkg::CMD_EXPO_SET: begin
          result_o.kind  = cfd_pkg::KIND_FORWARD;
          result_o.addr  = 8'h24;
          result_o.sub_a = 8'h04;
          result_o.sub_b = 8'h04;
          result_o.value = 32'd2;
        end
        cfd_pkg::CMD_FWD_A: begin
          result_o.kind  = cfd_pkg::KIND_FORWARD;
          result_o.addr  = 8'h44;
          result_o.sub_a = 8'h02;
          result_o.sub_b = 8'h03;
          result_o.value = frame_i.args;
        end
        cfd_pkg::CMD_FWD_B: begin
          result_o.kind  = cfd_pkg::KIND_FORWARD;
          result_o.addr  = 8'h64;
          result_o.sub_a = 8'h02;
          result_o.sub_b = 8'h03;
          result_o.value = frame_i.args;
        end
        cfd_pkg::CMD_START:
          result_o.kind = confirmed ? cfd_pkg::KIND_START : cfd_pkg::KIND_REJECTED;
        cfd_pkg::CMD_STOP:
          result_o.kind = confirmed ? cfd_pkg::KIND_STOP : cfd_pkg::KIND_REJECTED;
        cfd_pkg::CMD_XFER:
          result_o.kind = confirmed ? cfd_pkg::KIND_XFER : cfd_pkg::KIND_REJECTED;
        cfd_pkg::CMD_STOP_XFER:
          result_o.kind = confirmed ? cfd_pkg::KIND_STOP_XFER : cfd_pkg::KIND_REJECTED;
        cfd_pkg::CMD_POWER_OFF:
          result_o.kind = confirmed ? cfd_pkg::KIND_POWER_OFF : cfd_pkg::KIND_REJECTED;
        cfd_pkg::CMD_FORMAT:
          result_o.kind = confirmed ? cfd_pkg::KIND_FORMAT : cfd_pkg::KIND_REJECTED;
        cfd_pkg::CMD_FWD_C: begin
          result_o.kind  = cfd_pkg::KIND_FORWARD;
          result_o.addr  = 8'h24;
          result_o.sub_b = 8'h06;
          result_o.value = 32'd1;
        end
        default: result_o.kind = cfd_pkg::KIND_UNKNOWN;
      endcase
    end
  end

endmodule

// ===== src/cfd_out_reg.sv =====
// ----------------------------------------------------------------------------
// cfd_out_reg
// Result register that holds a decoded frame until the sink takes it.
// ----------------------------------------------------------------------------
module cfd_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_valid_i,
  input  cfd_pkg::result_t result_i,
  output logic             load_ready_o,
  output logic             valid_o,
  input  logic             ready_i,
  output cfd_pkg::result_t result_o
);

  logic             valid_q, valid_d;
  cfd_pkg::result_t result_q;

  assign load_ready_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_ready_o) begin
      valid_d = load_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_ready_o && load_valid_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule
